/* design/sipt_pkg.sv */
package sipt_pkg;

    localparam int SLOT_CNT = 256;
    localparam int SLOT_W   = $clog2(SLOT_CNT);
    localparam int T1_W     = 12;
    localparam int T2_W     = 16;
    localparam int IVL_W    = 27;
    localparam int MASK_W   = 10;
    localparam int RETRY_W  = 4;
    localparam int CODE_W   = 10;

    typedef enum logic [2:0] {
        OP_CREATE   = 3'd0,
        OP_REPLY_RX = 3'd1,
        OP_REPLY_TX = 3'd2,
        OP_ACK_RX   = 3'd3,
        OP_REQ_RETX = 3'd4,
        OP_TIMER    = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_CALLING    = 3'd0,
        ST_TRYING     = 3'd1,
        ST_PROCEEDING = 3'd2,
        ST_COMPLETED  = 3'd3,
        ST_CONFIRMED  = 3'd4,
        ST_TERM200    = 3'd5,
        ST_TERMINATED = 3'd6
    } t_txn_state;

    typedef enum logic [3:0] {
        TMR_A = 4'd0,
        TMR_B = 4'd1,
        TMR_D = 4'd2,
        TMR_E = 4'd3,
        TMR_F = 4'd4,
        TMR_G = 4'd5,
        TMR_H = 4'd6,
        TMR_I = 4'd7,
        TMR_J = 4'd8,
        TMR_K = 4'd9
    } t_timer;

    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_NO_TAG     = 2'd1,
        STS_LATE_REPLY = 2'd2,
        STS_INVALID    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'b01,
        FSM_EXEC = 2'b10
    } t_fsm;

    typedef struct packed {
        logic final_sent;
        logic invite;
        logic client;
    } t_flags;

    typedef struct packed {
        t_flags     flags;
        t_txn_state state;
    } t_entry;

    typedef enum logic [0:0] {
        REG_T1 = 1'b0,
        REG_T2 = 1'b1
    } t_reg;

    localparam logic [MASK_W-1:0] M_A = MASK_W'(1) << TMR_A;
    localparam logic [MASK_W-1:0] M_B = MASK_W'(1) << TMR_B;
    localparam logic [MASK_W-1:0] M_D = MASK_W'(1) << TMR_D;
    localparam logic [MASK_W-1:0] M_E = MASK_W'(1) << TMR_E;
    localparam logic [MASK_W-1:0] M_F = MASK_W'(1) << TMR_F;
    localparam logic [MASK_W-1:0] M_G = MASK_W'(1) << TMR_G;
    localparam logic [MASK_W-1:0] M_H = MASK_W'(1) << TMR_H;
    localparam logic [MASK_W-1:0] M_I = MASK_W'(1) << TMR_I;
    localparam logic [MASK_W-1:0] M_J = MASK_W'(1) << TMR_J;
    localparam logic [MASK_W-1:0] M_K = MASK_W'(1) << TMR_K;

    localparam logic [T1_W-1:0]    T1_RST    = T1_W'(500);
    localparam logic [T2_W-1:0]    T2_RST    = T2_W'(4000);
    localparam logic [CODE_W-1:0]  CODE_2XX  = CODE_W'(200);
    localparam logic [CODE_W-1:0]  CODE_3XX  = CODE_W'(300);
    localparam logic [RETRY_W-1:0] RETRY_MAX = {RETRY_W{1'b1}};

endpackage

/* design/sip_transaction_state_table_top.sv */
// channel   direction  handshake                     payload
// -------   ---------  ----------------------------  ---------------------------------
// event     in         i_in_valid / o_in_ready       i_op .. i_retry_in
// result    out        o_out_valid / i_out_ready     o_new_state .. o_status
// config    in         psel penable pwrite pready    paddr pwdata prdata (t1, t2)
//
// each event first reads the slot entry from the synchronous entry memory, then
// decodes the event and writes the entry back
// the next event is taken only after the write-back, so accesses never overlap
// reset clears the slot valid bits and loads t1 = 500, t2 = 4000
// a result waiting in the output register holds the decode cycle until taken
module sip_transaction_state_table_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [2:0]                   i_op,
    input  logic [sipt_pkg::SLOT_W-1:0]  i_slot,
    input  logic [sipt_pkg::CODE_W-1:0]  i_reply_code,
    input  logic                         i_has_to_tag,
    input  logic                         i_invite_flag,
    input  logic                         i_client_role,
    input  logic [3:0]                   i_timer_kind,
    input  logic [sipt_pkg::RETRY_W-1:0] i_retry_in,

    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [2:0]                   o_new_state,
    output logic                         o_remove_entry,
    output logic                         o_pass_to_ua,
    output logic                         o_send_ack,
    output logic                         o_retransmit,
    output logic [sipt_pkg::MASK_W-1:0]  o_arm_mask,
    output logic [sipt_pkg::MASK_W-1:0]  o_clear_mask,
    output logic [sipt_pkg::RETRY_W-1:0] o_retry_out,
    output logic [sipt_pkg::IVL_W-1:0]   o_retry_interval,
    output logic [1:0]                   o_status,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    sipt_pkg::t_fsm                 r_fsm;
    logic [sipt_pkg::T1_W-1:0]      r_t1;
    logic [sipt_pkg::T2_W-1:0]      r_t2;
    logic [sipt_pkg::SLOT_CNT-1:0]  r_slot_valid;
    sipt_pkg::t_entry               r_mem [sipt_pkg::SLOT_CNT];
    sipt_pkg::t_entry               r_rd;

    sipt_pkg::t_op                  r_op;
    logic                           r_op_bad;
    logic [sipt_pkg::SLOT_W-1:0]    r_slot;
    logic [sipt_pkg::CODE_W-1:0]    r_code;
    logic                           r_tag;
    logic                           r_inv;
    logic                           r_cli;
    logic [3:0]                     r_kind;
    logic [sipt_pkg::RETRY_W-1:0]   r_rin;

    logic                           r_out_valid;
    sipt_pkg::t_txn_state           r_ns;
    logic                           r_rm;
    logic                           r_pass;
    logic                           r_ack;
    logic                           r_rtx;
    logic [sipt_pkg::MASK_W-1:0]    r_arm;
    logic [sipt_pkg::MASK_W-1:0]    r_clr;
    logic [sipt_pkg::RETRY_W-1:0]   r_rout;
    logic [sipt_pkg::IVL_W-1:0]     r_rint;
    sipt_pkg::t_status              r_sts;

    sipt_pkg::t_txn_state           n_ns;
    logic                           n_rm;
    logic                           n_pass;
    logic                           n_ack;
    logic                           n_rtx;
    logic [sipt_pkg::MASK_W-1:0]    n_arm;
    logic [sipt_pkg::MASK_W-1:0]    n_clr;
    logic [sipt_pkg::RETRY_W-1:0]   n_rout;
    logic [sipt_pkg::IVL_W-1:0]     n_rint;
    sipt_pkg::t_status              n_sts;
    sipt_pkg::t_flags               n_fl;

    logic                           in_accept;
    logic                           cfg_write;
    logic                           exec_go;
    logic                           cur_valid;
    sipt_pkg::t_txn_state           cur;
    sipt_pkg::t_flags               fl;
    logic [sipt_pkg::RETRY_W-1:0]   nxt;
    logic [sipt_pkg::MASK_W-1:0]    kind_bit;
    logic                           mem_we;
    logic                           valid_set;
    logic                           valid_clr;

    function automatic logic [sipt_pkg::IVL_W-1:0] retry_len(
        input logic [sipt_pkg::T1_W-1:0]    t1,
        input logic [sipt_pkg::T2_W-1:0]    t2,
        input logic [sipt_pkg::RETRY_W-1:0] n,
        input logic                         capped
    );
        logic [sipt_pkg::IVL_W-1:0] iv;
        logic [sipt_pkg::IVL_W-1:0] cap;
        iv  = sipt_pkg::IVL_W'(t1) << n;
        cap = sipt_pkg::IVL_W'(t2);
        if (capped && (iv > cap)) begin
            iv = cap;
        end
        return iv;
    endfunction

    assign in_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = (r_fsm == sipt_pkg::FSM_IDLE);
    assign exec_go    = (r_fsm == sipt_pkg::FSM_EXEC) && (!r_out_valid || i_out_ready);

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        if (sipt_pkg::t_reg'(paddr[2]) == sipt_pkg::REG_T2) begin
            prdata = 32'(r_t2);
        end else begin
            prdata = 32'(r_t1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= sipt_pkg::T1_RST;
            r_t2 <= sipt_pkg::T2_RST;
        end else if (cfg_write) begin
            unique case (sipt_pkg::t_reg'(paddr[2]))
                sipt_pkg::REG_T1: r_t1 <= pwdata[sipt_pkg::T1_W-1:0];
                sipt_pkg::REG_T2: r_t2 <= pwdata[sipt_pkg::T2_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= sipt_pkg::FSM_IDLE;
        end else begin
            unique case (r_fsm)
                sipt_pkg::FSM_IDLE: begin
                    if (in_accept) begin
                        r_fsm <= sipt_pkg::FSM_EXEC;
                    end
                end
                sipt_pkg::FSM_EXEC: begin
                    if (exec_go) begin
                        r_fsm <= sipt_pkg::FSM_IDLE;
                    end
                end
                default: r_fsm <= sipt_pkg::FSM_IDLE;
            endcase
        end
    end

    // event capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op     <= sipt_pkg::t_op'(i_op);
            r_op_bad <= (i_op > sipt_pkg::OP_TIMER);
            r_slot   <= i_slot;
            r_code   <= i_reply_code;
            r_tag    <= i_has_to_tag;
            r_inv    <= i_invite_flag;
            r_cli    <= i_client_role;
            r_kind   <= i_timer_kind;
            r_rin    <= i_retry_in;
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_slot] <= '{flags: n_fl, state: n_ns};
        end
        if (in_accept) begin
            r_rd <= r_mem[i_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
        end else if (valid_set) begin
            r_slot_valid[r_slot] <= 1'b1;
        end else if (valid_clr) begin
            r_slot_valid[r_slot] <= 1'b0;
        end
    end

    assign cur_valid = r_slot_valid[r_slot];
    assign cur       = cur_valid ? r_rd.state : sipt_pkg::ST_TERMINATED;
    assign fl        = cur_valid ? r_rd.flags : '0;
    assign nxt       = (r_rin < sipt_pkg::RETRY_MAX) ? r_rin + 1'b1 : sipt_pkg::RETRY_MAX;
    assign kind_bit  = sipt_pkg::MASK_W'(1) << r_kind;

    // event decode
    always_comb begin
        n_ns   = cur;
        n_rm   = 1'b0;
        n_pass = 1'b0;
        n_ack  = 1'b0;
        n_rtx  = 1'b0;
        n_arm  = '0;
        n_clr  = '0;
        n_rout = '0;
        n_rint = '0;
        n_sts  = sipt_pkg::STS_OK;
        n_fl   = fl;

        if (r_op_bad) begin
            n_sts = sipt_pkg::STS_INVALID;
        end else if (r_op == sipt_pkg::OP_CREATE) begin
            if (cur_valid) begin
                n_sts = sipt_pkg::STS_INVALID;
            end else begin
                n_fl = '{final_sent: 1'b0, invite: r_inv, client: r_cli};
                if (r_cli && r_inv) begin
                    n_ns  = sipt_pkg::ST_CALLING;
                    n_arm = sipt_pkg::M_A | sipt_pkg::M_B;
                end else if (r_cli) begin
                    n_ns  = sipt_pkg::ST_TRYING;
                    n_arm = sipt_pkg::M_E | sipt_pkg::M_F;
                end else begin
                    n_ns  = sipt_pkg::ST_TRYING;
                end
                if (r_cli) begin
                    n_rint = retry_len(r_t1, r_t2, '0, 1'b0);
                end
            end
        end else if (!cur_valid) begin
            n_sts = sipt_pkg::STS_INVALID;
        end else begin
            unique case (r_op)
                sipt_pkg::OP_REPLY_RX: begin
                    if (!fl.client) begin
                        n_sts = sipt_pkg::STS_INVALID;
                    end else if (r_code < sipt_pkg::CODE_2XX) begin
                        if (cur == sipt_pkg::ST_CALLING || cur == sipt_pkg::ST_TRYING ||
                            cur == sipt_pkg::ST_PROCEEDING) begin
                            if (cur == sipt_pkg::ST_CALLING) begin
                                n_clr = sipt_pkg::M_A;
                            end
                            n_ns   = sipt_pkg::ST_PROCEEDING;
                            n_pass = 1'b1;
                        end
                    end else if (!r_tag) begin
                        n_sts = sipt_pkg::STS_NO_TAG;
                    end else if (fl.invite) begin
                        if (r_code >= sipt_pkg::CODE_3XX) begin
                            if (cur == sipt_pkg::ST_CALLING ||
                                cur == sipt_pkg::ST_PROCEEDING) begin
                                if (cur == sipt_pkg::ST_CALLING) begin
                                    n_clr = sipt_pkg::M_A;
                                end
                                n_ns   = sipt_pkg::ST_COMPLETED;
                                n_ack  = 1'b1;
                                n_arm  = sipt_pkg::M_D;
                                n_pass = 1'b1;
                            end else if (cur == sipt_pkg::ST_COMPLETED) begin
                                n_rtx = 1'b1;
                            end
                        end else if (cur == sipt_pkg::ST_CALLING ||
                                     cur == sipt_pkg::ST_PROCEEDING) begin
                            n_rm   = 1'b1;
                            n_pass = 1'b1;
                        end
                    end else if (cur == sipt_pkg::ST_CALLING || cur == sipt_pkg::ST_TRYING ||
                                 cur == sipt_pkg::ST_PROCEEDING) begin
                        n_ns   = sipt_pkg::ST_COMPLETED;
                        n_arm  = sipt_pkg::M_K;
                        n_pass = 1'b1;
                    end
                end
                sipt_pkg::OP_REPLY_TX: begin
                    if (fl.client) begin
                        n_sts = sipt_pkg::STS_INVALID;
                    end else if (fl.final_sent) begin
                        n_sts = sipt_pkg::STS_LATE_REPLY;
                    end else if (r_code >= sipt_pkg::CODE_3XX) begin
                        n_fl.final_sent = 1'b1;
                        n_ns            = sipt_pkg::ST_COMPLETED;
                        if (fl.invite) begin
                            n_arm  = sipt_pkg::M_G | sipt_pkg::M_H;
                            n_rint = retry_len(r_t1, r_t2, '0, 1'b1);
                        end else begin
                            n_arm = sipt_pkg::M_J;
                        end
                    end else if (r_code >= sipt_pkg::CODE_2XX) begin
                        n_fl.final_sent = 1'b1;
                        if (fl.invite) begin
                            n_ns = sipt_pkg::ST_TERM200;
                        end else begin
                            n_ns  = sipt_pkg::ST_COMPLETED;
                            n_arm = sipt_pkg::M_J;
                        end
                    end else begin
                        n_ns = sipt_pkg::ST_PROCEEDING;
                    end
                end
                sipt_pkg::OP_ACK_RX: begin
                    if (fl.client || !fl.invite) begin
                        n_sts = sipt_pkg::STS_INVALID;
                    end else if (cur == sipt_pkg::ST_COMPLETED) begin
                        n_ns  = sipt_pkg::ST_CONFIRMED;
                        n_clr = sipt_pkg::M_G | sipt_pkg::M_H;
                        n_arm = sipt_pkg::M_I;
                    end else if (cur == sipt_pkg::ST_TERM200) begin
                        n_rm = 1'b1;
                    end else if (cur != sipt_pkg::ST_CONFIRMED) begin
                        n_sts = sipt_pkg::STS_INVALID;
                    end
                end
                sipt_pkg::OP_REQ_RETX: begin
                    if (fl.client) begin
                        n_sts = sipt_pkg::STS_INVALID;
                    end else if (cur == sipt_pkg::ST_PROCEEDING ||
                                 cur == sipt_pkg::ST_COMPLETED ||
                                 cur == sipt_pkg::ST_TERM200) begin
                        n_rtx = 1'b1;
                    end
                end
                sipt_pkg::OP_TIMER: begin
                    case (r_kind) inside
                        sipt_pkg::TMR_A: begin
                            n_rtx  = 1'b1;
                            n_arm  = sipt_pkg::M_A;
                            n_rout = nxt;
                            n_rint = retry_len(r_t1, r_t2, nxt, 1'b0);
                        end
                        sipt_pkg::TMR_E, sipt_pkg::TMR_G: begin
                            n_rtx  = 1'b1;
                            n_arm  = kind_bit;
                            n_rout = nxt;
                            n_rint = retry_len(r_t1, r_t2, nxt, 1'b1);
                        end
                        sipt_pkg::TMR_B, sipt_pkg::TMR_F: begin
                            n_clr = kind_bit;
                            if (cur == sipt_pkg::ST_CALLING) begin
                                n_clr = kind_bit | sipt_pkg::M_A;
                                n_rm  = 1'b1;
                            end else if (cur == sipt_pkg::ST_TRYING ||
                                         cur == sipt_pkg::ST_PROCEEDING) begin
                                n_clr = kind_bit | sipt_pkg::M_E;
                                n_rm  = 1'b1;
                            end
                        end
                        sipt_pkg::TMR_D, sipt_pkg::TMR_H, sipt_pkg::TMR_I,
                        sipt_pkg::TMR_J, sipt_pkg::TMR_K: begin
                            n_clr = kind_bit;
                            n_rm  = 1'b1;
                        end
                        default: n_sts = sipt_pkg::STS_INVALID;
                    endcase
                end
                default: n_sts = sipt_pkg::STS_INVALID;
            endcase
        end

        if (n_sts == sipt_pkg::STS_INVALID) begin
            n_rm   = 1'b0;
            n_pass = 1'b0;
            n_ack  = 1'b0;
            n_rtx  = 1'b0;
            n_arm  = '0;
            n_clr  = '0;
            n_rout = '0;
            n_rint = '0;
            n_ns   = cur;
        end else if (n_sts != sipt_pkg::STS_OK) begin
            n_ns = cur;
        end else if (n_rm) begin
            n_ns = sipt_pkg::ST_TERMINATED;
        end
    end

    assign mem_we    = exec_go && (n_sts == sipt_pkg::STS_OK) && !n_rm;
    assign valid_set = mem_we && !r_op_bad && (r_op == sipt_pkg::OP_CREATE);
    assign valid_clr = exec_go && (n_sts == sipt_pkg::STS_OK) && n_rm;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_ns   <= n_ns;
            r_rm   <= n_rm;
            r_pass <= n_pass;
            r_ack  <= n_ack;
            r_rtx  <= n_rtx;
            r_arm  <= n_arm;
            r_clr  <= n_clr;
            r_rout <= n_rout;
            r_rint <= n_rint;
            r_sts  <= n_sts;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_new_state      = r_ns;
    assign o_remove_entry   = r_rm;
    assign o_pass_to_ua     = r_pass;
    assign o_send_ack       = r_ack;
    assign o_retransmit     = r_rtx;
    assign o_arm_mask       = r_arm;
    assign o_clear_mask     = r_clr;
    assign o_retry_out      = r_rout;
    assign o_retry_interval = r_rint;
    assign o_status         = r_sts;

endmodule

/* verif/testbench.sv */
module testbench;

    typedef struct packed {
        logic [2:0]                   op;
        logic [sipt_pkg::SLOT_W-1:0]  slot;
        logic [sipt_pkg::CODE_W-1:0]  code;
        logic                         tag;
        logic                         inv;
        logic                         cli;
        logic [3:0]                   kind;
        logic [sipt_pkg::RETRY_W-1:0] rin;
    } t_txn;

    typedef struct packed {
        logic [2:0]                   new_state;
        logic                         remove_entry;
        logic                         pass_to_ua;
        logic                         send_ack;
        logic                         retransmit;
        logic [sipt_pkg::MASK_W-1:0]  arm_mask;
        logic [sipt_pkg::MASK_W-1:0]  clear_mask;
        logic [sipt_pkg::RETRY_W-1:0] retry_out;
        logic [sipt_pkg::IVL_W-1:0]   retry_interval;
        logic [1:0]                   status;
    } t_outcome;

    typedef struct packed {
        t_txn     txn;
        logic     typed;
        t_outcome want;
    } t_dir_row;

    localparam int       N_DIR         = 26;
    localparam int       N_CFG         = 5;
    localparam int       ITEMS_PER_CFG = 100;
    localparam int       HOLD_AT       = 150;
    localparam int       HOLD_CYCLES   = 400;
    localparam int       CYCLE_LIMIT   = 200000;
    localparam int       MAX_PRINTS    = 100;
    localparam int       PEND_DEPTH    = 16;
    localparam logic     TYPED         = 1'b1;
    localparam logic     PREDICTED     = 1'b0;
    localparam t_outcome NO_WANT       = '0;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic [2:0]                   i_op;
    logic [sipt_pkg::SLOT_W-1:0]  i_slot;
    logic [sipt_pkg::CODE_W-1:0]  i_reply_code;
    logic                         i_has_to_tag;
    logic                         i_invite_flag;
    logic                         i_client_role;
    logic [3:0]                   i_timer_kind;
    logic [sipt_pkg::RETRY_W-1:0] i_retry_in;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic [2:0]                   o_new_state;
    logic                         o_remove_entry;
    logic                         o_pass_to_ua;
    logic                         o_send_ack;
    logic                         o_retransmit;
    logic [sipt_pkg::MASK_W-1:0]  o_arm_mask;
    logic [sipt_pkg::MASK_W-1:0]  o_clear_mask;
    logic [sipt_pkg::RETRY_W-1:0] o_retry_out;
    logic [sipt_pkg::IVL_W-1:0]   o_retry_interval;
    logic [1:0]                   o_status;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [2:0]                   paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;

    // shadow of the slot table and timer registers
    logic [sipt_pkg::T1_W-1:0]    t1_ticks;
    logic [sipt_pkg::T2_W-1:0]    t2_ticks;
    logic                         slot_live [sipt_pkg::SLOT_CNT];
    sipt_pkg::t_txn_state         slot_st   [sipt_pkg::SLOT_CNT];
    sipt_pkg::t_flags             slot_fl   [sipt_pkg::SLOT_CNT];

    // pending outcomes in order of acceptance
    t_outcome                     pending [PEND_DEPTH];
    int                           pend_wr = 0;
    int                           pend_rd = 0;

    int fail_count  = 0;
    int cycle_count = 0;
    int rx_count    = 0;

    sip_transaction_state_table_top u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("testbench: FAIL");
        $finish;
    end

    function automatic logic [sipt_pkg::IVL_W-1:0] retry_ticks(
        logic [sipt_pkg::RETRY_W-1:0] n, logic capped);
        logic [31:0] iv;
        iv = 32'(t1_ticks) << n;
        if (capped && iv > 32'(t2_ticks)) begin
            iv = 32'(t2_ticks);
        end
        return iv[sipt_pkg::IVL_W-1:0];
    endfunction

    function automatic t_outcome advance_slot_fsm(t_txn tx);
        t_outcome                     o;
        logic                         live;
        sipt_pkg::t_txn_state         cur;
        sipt_pkg::t_txn_state         ns;
        sipt_pkg::t_flags             fl;
        logic [sipt_pkg::RETRY_W-1:0] nxt;
        logic [sipt_pkg::MASK_W-1:0]  kbit;
        o    = '0;
        live = slot_live[tx.slot];
        cur  = live ? slot_st[tx.slot] : sipt_pkg::ST_TERMINATED;
        fl   = live ? slot_fl[tx.slot] : '0;
        ns   = cur;
        if (tx.op > sipt_pkg::OP_TIMER) begin
            o.status = sipt_pkg::STS_INVALID;
        end else if (tx.op == sipt_pkg::OP_CREATE) begin
            if (live) begin
                o.status = sipt_pkg::STS_INVALID;
            end else begin
                fl        = '0;
                fl.client = tx.cli;
                fl.invite = tx.inv;
                ns        = sipt_pkg::ST_TRYING;
                if (tx.cli && tx.inv) begin
                    ns         = sipt_pkg::ST_CALLING;
                    o.arm_mask = sipt_pkg::M_A | sipt_pkg::M_B;
                end else if (tx.cli) begin
                    o.arm_mask = sipt_pkg::M_E | sipt_pkg::M_F;
                end
                if (tx.cli) begin
                    o.retry_interval = retry_ticks('0, 1'b0);
                end
                slot_live[tx.slot] = 1'b1;
                slot_fl[tx.slot]   = fl;
            end
        end else if (!live) begin
            o.status = sipt_pkg::STS_INVALID;
        end else begin
            case (tx.op)
                sipt_pkg::OP_REPLY_RX: begin
                    if (!fl.client) begin
                        o.status = sipt_pkg::STS_INVALID;
                    end else if (tx.code < sipt_pkg::CODE_2XX) begin
                        if (cur inside {sipt_pkg::ST_CALLING, sipt_pkg::ST_TRYING,
                                        sipt_pkg::ST_PROCEEDING}) begin
                            if (cur == sipt_pkg::ST_CALLING) begin
                                o.clear_mask = sipt_pkg::M_A;
                            end
                            ns           = sipt_pkg::ST_PROCEEDING;
                            o.pass_to_ua = 1'b1;
                        end
                    end else if (!tx.tag) begin
                        o.status = sipt_pkg::STS_NO_TAG;
                    end else if (fl.invite) begin
                        if (tx.code >= sipt_pkg::CODE_3XX) begin
                            if (cur inside {sipt_pkg::ST_CALLING,
                                            sipt_pkg::ST_PROCEEDING}) begin
                                if (cur == sipt_pkg::ST_CALLING) begin
                                    o.clear_mask = sipt_pkg::M_A;
                                end
                                ns           = sipt_pkg::ST_COMPLETED;
                                o.send_ack   = 1'b1;
                                o.arm_mask   = sipt_pkg::M_D;
                                o.pass_to_ua = 1'b1;
                            end else if (cur == sipt_pkg::ST_COMPLETED) begin
                                o.retransmit = 1'b1;
                            end
                        end else if (cur inside {sipt_pkg::ST_CALLING,
                                                 sipt_pkg::ST_PROCEEDING}) begin
                            o.remove_entry = 1'b1;
                            o.pass_to_ua   = 1'b1;
                        end
                    end else if (cur inside {sipt_pkg::ST_CALLING, sipt_pkg::ST_TRYING,
                                             sipt_pkg::ST_PROCEEDING}) begin
                        ns           = sipt_pkg::ST_COMPLETED;
                        o.arm_mask   = sipt_pkg::M_K;
                        o.pass_to_ua = 1'b1;
                    end
                end
                sipt_pkg::OP_REPLY_TX: begin
                    if (fl.client) begin
                        o.status = sipt_pkg::STS_INVALID;
                    end else if (fl.final_sent) begin
                        o.status = sipt_pkg::STS_LATE_REPLY;
                    end else if (tx.code >= sipt_pkg::CODE_3XX) begin
                        fl.final_sent = 1'b1;
                        ns            = sipt_pkg::ST_COMPLETED;
                        if (fl.invite) begin
                            o.arm_mask       = sipt_pkg::M_G | sipt_pkg::M_H;
                            o.retry_interval = retry_ticks('0, 1'b1);
                        end else begin
                            o.arm_mask = sipt_pkg::M_J;
                        end
                    end else if (tx.code >= sipt_pkg::CODE_2XX) begin
                        fl.final_sent = 1'b1;
                        if (fl.invite) begin
                            ns = sipt_pkg::ST_TERM200;
                        end else begin
                            ns         = sipt_pkg::ST_COMPLETED;
                            o.arm_mask = sipt_pkg::M_J;
                        end
                    end else begin
                        ns = sipt_pkg::ST_PROCEEDING;
                    end
                    if (o.status == sipt_pkg::STS_OK) begin
                        slot_fl[tx.slot] = fl;
                    end
                end
                sipt_pkg::OP_ACK_RX: begin
                    if (fl.client || !fl.invite) begin
                        o.status = sipt_pkg::STS_INVALID;
                    end else if (cur == sipt_pkg::ST_COMPLETED) begin
                        ns           = sipt_pkg::ST_CONFIRMED;
                        o.clear_mask = sipt_pkg::M_G | sipt_pkg::M_H;
                        o.arm_mask   = sipt_pkg::M_I;
                    end else if (cur == sipt_pkg::ST_TERM200) begin
                        o.remove_entry = 1'b1;
                    end else if (cur != sipt_pkg::ST_CONFIRMED) begin
                        o.status = sipt_pkg::STS_INVALID;
                    end
                end
                sipt_pkg::OP_REQ_RETX: begin
                    if (fl.client) begin
                        o.status = sipt_pkg::STS_INVALID;
                    end else if (cur inside {sipt_pkg::ST_PROCEEDING, sipt_pkg::ST_COMPLETED,
                                             sipt_pkg::ST_TERM200}) begin
                        o.retransmit = 1'b1;
                    end
                end
                default: begin
                    nxt  = (tx.rin == sipt_pkg::RETRY_MAX) ? sipt_pkg::RETRY_MAX
                                                            : tx.rin + 1'b1;
                    kbit = sipt_pkg::MASK_W'(1) << tx.kind;
                    case (tx.kind)
                        sipt_pkg::TMR_A: begin
                            o.retransmit     = 1'b1;
                            o.arm_mask       = sipt_pkg::M_A;
                            o.retry_out      = nxt;
                            o.retry_interval = retry_ticks(nxt, 1'b0);
                        end
                        sipt_pkg::TMR_E, sipt_pkg::TMR_G: begin
                            o.retransmit     = 1'b1;
                            o.arm_mask       = kbit;
                            o.retry_out      = nxt;
                            o.retry_interval = retry_ticks(nxt, 1'b1);
                        end
                        sipt_pkg::TMR_B, sipt_pkg::TMR_F: begin
                            o.clear_mask = kbit;
                            if (cur == sipt_pkg::ST_CALLING) begin
                                o.clear_mask   = o.clear_mask | sipt_pkg::M_A;
                                o.remove_entry = 1'b1;
                            end else if (cur inside {sipt_pkg::ST_TRYING,
                                                     sipt_pkg::ST_PROCEEDING}) begin
                                o.clear_mask   = o.clear_mask | sipt_pkg::M_E;
                                o.remove_entry = 1'b1;
                            end
                        end
                        sipt_pkg::TMR_D, sipt_pkg::TMR_H, sipt_pkg::TMR_I,
                        sipt_pkg::TMR_J, sipt_pkg::TMR_K: begin
                            o.clear_mask   = kbit;
                            o.remove_entry = 1'b1;
                        end
                        default: begin
                            o.status = sipt_pkg::STS_INVALID;
                        end
                    endcase
                end
            endcase
        end
        if (o.status == sipt_pkg::STS_INVALID) begin
            o           = '0;
            o.status    = sipt_pkg::STS_INVALID;
            o.new_state = live ? cur : sipt_pkg::ST_TERMINATED;
        end else if (o.status != sipt_pkg::STS_OK) begin
            o.new_state = cur;
        end else if (o.remove_entry) begin
            o.new_state        = sipt_pkg::ST_TERMINATED;
            slot_live[tx.slot] = 1'b0;
        end else begin
            o.new_state      = ns;
            slot_st[tx.slot] = ns;
        end
        return o;
    endfunction

    function automatic t_txn txn(logic [2:0] op, logic [sipt_pkg::SLOT_W-1:0] slot,
                                 logic [sipt_pkg::CODE_W-1:0] code, logic tag, logic inv,
                                 logic cli, logic [3:0] kind,
                                 logic [sipt_pkg::RETRY_W-1:0] rin);
        t_txn tx;
        tx = '{op, slot, code, tag, inv, cli, kind, rin};
        return tx;
    endfunction

    function automatic t_outcome known_outcome(sipt_pkg::t_txn_state st,
                                               sipt_pkg::t_status sts,
                                               logic [sipt_pkg::MASK_W-1:0] arm,
                                               logic [sipt_pkg::IVL_W-1:0] rint);
        t_outcome o;
        o                = '0;
        o.new_state      = st;
        o.status         = sts;
        o.arm_mask       = arm;
        o.retry_interval = rint;
        return o;
    endfunction

    // mostly sensible events on a few busy slots, the rest raw noise
    function automatic t_txn draw_txn();
        t_txn tx;
        tx.op   = 3'($urandom_range(0, 7));
        tx.slot = sipt_pkg::SLOT_W'($urandom);
        tx.code = sipt_pkg::CODE_W'($urandom);
        tx.tag  = 1'($urandom);
        tx.inv  = 1'($urandom);
        tx.cli  = 1'($urandom);
        tx.kind = 4'($urandom);
        tx.rin  = sipt_pkg::RETRY_W'($urandom);
        if ($urandom_range(0, 99) < 12) begin
            return tx;
        end
        if ($urandom_range(0, 9) != 0) begin
            tx.slot = sipt_pkg::SLOT_W'($urandom_range(0, 7));
        end
        tx.code = sipt_pkg::CODE_W'($urandom_range(100, 699));
        tx.kind = 4'($urandom_range(0, 9));
        tx.tag  = ($urandom_range(0, 7) != 0);
        if (!slot_live[tx.slot]) begin
            tx.op = sipt_pkg::OP_CREATE;
        end else if (slot_fl[tx.slot].client) begin
            tx.op = ($urandom_range(0, 2) == 0) ? sipt_pkg::OP_TIMER : sipt_pkg::OP_REPLY_RX;
        end else begin
            case ($urandom_range(0, 4))
                0, 3:    tx.op = sipt_pkg::OP_REPLY_TX;
                1:       tx.op = sipt_pkg::OP_REQ_RETX;
                2:       tx.op = sipt_pkg::OP_ACK_RX;
                default: tx.op = sipt_pkg::OP_TIMER;
            endcase
        end
        return tx;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        fail_count++;
        if (fail_count <= MAX_PRINTS) begin
            $display("mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
                     field, rx_count, got, want);
        end
    endtask

    task automatic compare_outcome(t_outcome got, t_outcome want);
        if (got.new_state !== want.new_state)
            report_mismatch("new_state", 32'(got.new_state), 32'(want.new_state));
        if (got.remove_entry !== want.remove_entry)
            report_mismatch("remove_entry", 32'(got.remove_entry), 32'(want.remove_entry));
        if (got.pass_to_ua !== want.pass_to_ua)
            report_mismatch("pass_to_ua", 32'(got.pass_to_ua), 32'(want.pass_to_ua));
        if (got.send_ack !== want.send_ack)
            report_mismatch("send_ack", 32'(got.send_ack), 32'(want.send_ack));
        if (got.retransmit !== want.retransmit)
            report_mismatch("retransmit", 32'(got.retransmit), 32'(want.retransmit));
        if (got.arm_mask !== want.arm_mask)
            report_mismatch("arm_mask", 32'(got.arm_mask), 32'(want.arm_mask));
        if (got.clear_mask !== want.clear_mask)
            report_mismatch("clear_mask", 32'(got.clear_mask), 32'(want.clear_mask));
        if (got.retry_out !== want.retry_out)
            report_mismatch("retry_out", 32'(got.retry_out), 32'(want.retry_out));
        if (got.retry_interval !== want.retry_interval)
            report_mismatch("retry_interval", 32'(got.retry_interval),
                            32'(want.retry_interval));
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
    endtask

    task automatic send_txn(t_txn tx, logic typed, t_outcome want, int gap);
        t_outcome predicted;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= tx.op;
        i_slot        <= tx.slot;
        i_reply_code  <= tx.code;
        i_has_to_tag  <= tx.tag;
        i_invite_flag <= tx.inv;
        i_client_role <= tx.cli;
        i_timer_kind  <= tx.kind;
        i_retry_in    <= tx.rin;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predicted = advance_slot_fsm(tx);
        pending[pend_wr % PEND_DEPTH] = typed ? want : predicted;
        pend_wr++;
    endtask

    task automatic drain_outcomes();
        i_in_valid <= 1'b0;
        while (pend_wr != pend_rd) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(sipt_pkg::t_reg idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            sipt_pkg::REG_T1: t1_ticks = value[sipt_pkg::T1_W-1:0];
            default:          t2_ticks = value[sipt_pkg::T2_W-1:0];
        endcase
        @(posedge i_clk);
    endtask

    // result side: random stall per transaction, quiet stretches, one long hold-off
    initial begin
        t_outcome got;
        int       stall;
        stall       = 0;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
                got = {o_new_state, o_remove_entry, o_pass_to_ua, o_send_ack, o_retransmit,
                       o_arm_mask, o_clear_mask, o_retry_out, o_retry_interval, o_status};
                if (pend_wr == pend_rd) begin
                    report_mismatch("result with no pending transaction", 32'd1, 32'd0);
                end else begin
                    compare_outcome(got, pending[pend_rd % PEND_DEPTH]);
                    pend_rd++;
                end
                rx_count++;
                if (rx_count == HOLD_AT) begin
                    stall = HOLD_CYCLES;
                end else if ((rx_count / 60) % 3 == 1) begin
                    stall = 0;
                end else begin
                    stall = $urandom_range(0, 5);
                end
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_dir_row dir_table [N_DIR];
        int       gap;
        int       t1v;
        int       t2v;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_op          = '0;
        i_slot        = '0;
        i_reply_code  = '0;
        i_has_to_tag  = 1'b0;
        i_invite_flag = 1'b0;
        i_client_role = 1'b0;
        i_timer_kind  = '0;
        i_retry_in    = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        t1_ticks      = sipt_pkg::T1_RST;
        t2_ticks      = sipt_pkg::T2_RST;
        for (int s = 0; s < sipt_pkg::SLOT_CNT; s++) begin
            slot_live[s] = 1'b0;
        end

        dir_table = '{
            '{txn(sipt_pkg::OP_REPLY_RX, 8'd0, 10'd200, 1'b1, 1'b0, 1'b1,
                  sipt_pkg::TMR_A, 4'd0),
              TYPED, known_outcome(sipt_pkg::ST_TERMINATED, sipt_pkg::STS_INVALID, '0, '0)},
            '{txn(3'd7, 8'd255, 10'd1023, 1'b1, 1'b1, 1'b1, sipt_pkg::TMR_K, 4'd15),
              TYPED, known_outcome(sipt_pkg::ST_TERMINATED, sipt_pkg::STS_INVALID, '0, '0)},
            '{txn(sipt_pkg::OP_CREATE, 8'd0, 10'd100, 1'b0, 1'b1, 1'b1,
                  sipt_pkg::TMR_A, 4'd0),
              TYPED, known_outcome(sipt_pkg::ST_CALLING, sipt_pkg::STS_OK,
                                   sipt_pkg::M_A | sipt_pkg::M_B,
                                   sipt_pkg::IVL_W'(sipt_pkg::T1_RST))},
            '{txn(sipt_pkg::OP_CREATE, 8'd0, 10'd100, 1'b0, 1'b0, 1'b0,
                  sipt_pkg::TMR_A, 4'd0),
              TYPED, known_outcome(sipt_pkg::ST_CALLING, sipt_pkg::STS_INVALID, '0, '0)},
            '{txn(sipt_pkg::OP_TIMER, 8'd0, 10'd100, 1'b0, 1'b0, 1'b0,
                  sipt_pkg::TMR_A, 4'd15), PREDICTED, NO_WANT},
            '{txn(sipt_pkg::OP_REPLY_RX, 8'd0, 10'd100, 1'b0, 1'b0, 1'b0,
                  sipt_pkg::TMR_A, 4'd0), PREDICTED, NO_WANT},
            '{txn(sipt_pkg::OP_REPLY_RX, 8'd0, 10'd699, 1'b0, 1'b0, 1'b0,
                  sipt_pkg::TMR_A, 4'd0),
              TYPED, known_outcome(sipt_pkg::ST_PROCEEDING, sipt_pkg::STS_NO_TAG, '0, '0)},
            '{txn(sipt_pkg::OP_REPLY_RX, 8'd0, 10'd486, 1'b1, 1'b0, 1'b0,
                  sipt_pkg::TMR_A, 4'd0), PREDICTED, NO_WANT},
            '{txn(sipt_pkg::OP_REPLY_RX, 8'd0, 10'd500, 1'b1, 1'b0, 1'b0,
                  sipt_pkg::TMR_A, 4'd0), PREDICTED, NO_WANT},
            '{txn(sipt_pkg::OP_TIMER, 8'd0, 10'd100, 1'b0, 1'b0, 1'b0,
                  sipt_pkg::TMR_D, 4'd0), PREDICTED, NO_WANT},
            '{txn(sipt_pkg::OP_CREATE, 8'd255, 10'd100, 1'b0, 1'b0, 1'b1,
                  sipt_pkg::TMR_A, 4'd0), PREDICTED, NO_WANT},
            '{txn(sipt_pkg::OP_TIMER, 8'd255, 10'd100, 1'b0, 1'b0, 1'b0,
                  sipt_pkg::TMR_E, 4'd14), PREDICTED, NO_WANT},
            '{txn(sipt_pkg::OP_REPLY_RX, 8'd255, 10'd200, 1'b1, 1'b0, 1'b0,
                  sipt_pkg::TMR_A, 4'd0), PREDICTED, NO_WANT},
            '{txn(sipt_pkg::OP_TIMER, 8'd255, 10'd100, 1'b0, 1'b0, 1'b0,
                  sipt_pkg::TMR_K, 4'd0), PREDICTED, NO_WANT},
            '{txn(sipt_pkg::OP_CREATE, 8'd1, 10'd100, 1'b0, 1'b1, 1'b0,
                  sipt_pkg::TMR_A, 4'd0), PREDICTED, NO_WANT},
            '{txn(sipt_pkg::OP_ACK_RX, 8'd1, 10'd100, 1'b0, 1'b0, 1'b0,
                  sipt_pkg::TMR_A, 4'd0),
              TYPED, known_outcome(sipt_pkg::ST_TRYING, sipt_pkg::STS_INVALID, '0, '0)},
            '{txn(sipt_pkg::OP_REPLY_TX, 8'd1, 10'd180, 1'b0, 1'b0, 1'b0,
                  sipt_pkg::TMR_A, 4'd0), PREDICTED, NO_WANT},
            '{txn(sipt_pkg::OP_REQ_RETX, 8'd1, 10'd100, 1'b0, 1'b0, 1'b0,
                  sipt_pkg::TMR_A, 4'd0), PREDICTED, NO_WANT},
            '{txn(sipt_pkg::OP_REPLY_TX, 8'd1, 10'd603, 1'b0, 1'b0, 1'b0,
                  sipt_pkg::TMR_A, 4'd0), PREDICTED, NO_WANT},
            '{txn(sipt_pkg::OP_REPLY_TX, 8'd1, 10'd200, 1'b0, 1'b0, 1'b0,
                  sipt_pkg::TMR_A, 4'd0),
              TYPED, known_outcome(sipt_pkg::ST_COMPLETED, sipt_pkg::STS_LATE_REPLY,
                                   '0, '0)},
            '{txn(sipt_pkg::OP_TIMER, 8'd1, 10'd100, 1'b0, 1'b0, 1'b0,
                  sipt_pkg::TMR_G, 4'd3), PREDICTED, NO_WANT},
            '{txn(sipt_pkg::OP_ACK_RX, 8'd1, 10'd100, 1'b0, 1'b0, 1'b0,
                  sipt_pkg::TMR_A, 4'd0), PREDICTED, NO_WANT},
            '{txn(sipt_pkg::OP_TIMER, 8'd1, 10'd100, 1'b0, 1'b0, 1'b0, 4'hF, 4'd0),
              TYPED, known_outcome(sipt_pkg::ST_CONFIRMED, sipt_pkg::STS_INVALID, '0, '0)},
            '{txn(sipt_pkg::OP_TIMER, 8'd1, 10'd100, 1'b0, 1'b0, 1'b0,
                  sipt_pkg::TMR_I, 4'd0), PREDICTED, NO_WANT},
            '{txn(sipt_pkg::OP_CREATE, 8'd2, 10'd100, 1'b0, 1'b0, 1'b0,
                  sipt_pkg::TMR_A, 4'd0), PREDICTED, NO_WANT},
            '{txn(sipt_pkg::OP_REPLY_RX, 8'd2, 10'd200, 1'b1, 1'b0, 1'b0,
                  sipt_pkg::TMR_A, 4'd0),
              TYPED, known_outcome(sipt_pkg::ST_TRYING, sipt_pkg::STS_INVALID, '0, '0)}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            gap = $urandom_range(0, 5);
            send_txn(dir_table[r].txn, dir_table[r].typed, dir_table[r].want, gap);
        end

        for (int c = 0; c < N_CFG; c++) begin
            drain_outcomes();
            case (c)
                0: begin
                    t1v = 1;
                    t2v = 1;
                end
                1: begin
                    t1v = 4095;
                    t2v = 65535;
                end
                2: begin
                    t1v = 4095;
                    t2v = 1;
                end
                3: begin
                    t1v = 1;
                    t2v = 65535;
                end
                default: begin
                    t1v = $urandom_range(1, 4095);
                    t2v = $urandom_range(1, 65535);
                end
            endcase
            write_reg(sipt_pkg::REG_T1, 32'(t1v));
            write_reg(sipt_pkg::REG_T2, 32'(t2v));
            for (int n = 0; n < ITEMS_PER_CFG; n++) begin
                gap = ((n / 25) % 4 == 2) ? 0 : $urandom_range(0, 5);
                send_txn(draw_txn(), PREDICTED, NO_WANT, gap);
            end
        end

        drain_outcomes();
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

/* sip_transaction_state_table_top.f */
design/sipt_pkg.sv
design/sip_transaction_state_table_top.sv
verif/testbench.sv
